FILE: design/mcr_pkg.sv
// Shared types and constants for the midpoint circle rasterizer.
package mcr_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int CALC_W         = 17;
  localparam int QUEUE_DEPTH    = 2;
  localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  localparam logic [15:0] D_INIT    = 16'd3;
  localparam logic [15:0] D_INC_NEG = 16'd6;
  localparam logic [15:0] D_INC_POS = 16'd10;

  localparam logic [2:0] OCT_LAST = 3'd7;

  typedef struct packed {
    logic signed [11:0] cx;
    logic signed [11:0] cy;
    logic [23:0]        color;
    logic [10:0]        x;
    logic [10:0]        y;
    logic               done;
  } mcr_job_t;

endpackage

FILE: design/mcr_front.sv
// Command front end: circle walk state and job issue.
module mcr_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               command,
  input  logic signed [11:0] center_x,
  input  logic signed [11:0] center_y,
  input  logic [9:0]         radius,
  input  logic [23:0]        color_rgb,
  input  logic               q_full,
  output logic               push,
  output mcr_pkg::mcr_job_t  push_job
);
  import mcr_pkg::*;

  logic signed [11:0] cx;
  logic signed [11:0] cy;
  logic [23:0]        color;
  logic [10:0]        cur_x;
  logic [10:0]        cur_y;
  logic [13:0]        decision;
  logic               finished;

  logic        accept;
  logic        done;
  logic [15:0] d_ext;
  logic [15:0] x_ext;
  logic [15:0] y_ext;
  logic [15:0] d_sum;
  logic [15:0] d_start;
  logic [13:0] decision_next;
  logic [10:0] cur_y_next;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign done     = !(cur_x < cur_y);
  assign push     = accept && (command == CMD_STEP) && !finished;

  always_comb begin
    push_job.cx    = cx;
    push_job.cy    = cy;
    push_job.color = color;
    push_job.x     = cur_x;
    push_job.y     = cur_y;
    push_job.done  = done;
  end

  always_comb begin
    d_ext   = {{2{decision[13]}}, decision};
    x_ext   = {5'd0, cur_x};
    y_ext   = {5'd0, cur_y};
    d_start = D_INIT - {5'd0, radius, 1'b0};
    if (decision[13]) begin
      d_sum      = d_ext + (x_ext << 2) + D_INC_NEG;
      cur_y_next = cur_y;
    end else begin
      d_sum      = d_ext + ((x_ext - y_ext) << 2) + D_INC_POS;
      cur_y_next = cur_y - 11'd1;
    end
    decision_next = d_sum[13:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cx       <= '0;
      cy       <= '0;
      color    <= '0;
      cur_x    <= '0;
      cur_y    <= '0;
      decision <= '0;
      finished <= 1'b1;
    end else if (accept) begin
      if (command == CMD_START) begin
        cx       <= center_x;
        cy       <= center_y;
        color    <= color_rgb;
        cur_x    <= '0;
        cur_y    <= {1'b0, radius};
        decision <= d_start[13:0];
        finished <= 1'b0;
      end else if (!finished) begin
        if (done) begin
          finished <= 1'b1;
        end else begin
          cur_x    <= cur_x + 11'd1;
          cur_y    <= cur_y_next;
          decision <= decision_next;
        end
      end
    end
  end

  a_push_room: assert property (@(posedge clk) disable iff (rst) push |-> !q_full)
    else $error("job issued into a full queue");
  a_finish: assert property (@(posedge clk) disable iff (rst) (push && done) |=> finished)
    else $error("final step did not finish the circle");
  a_start: assert property (@(posedge clk) disable iff (rst)
    (accept && command == CMD_START) |=> (!finished && cur_x == 11'd0))
    else $error("start did not reset the walk");

endmodule

FILE: design/mcr_queue.sv
// Two-entry job queue between front end and pixel emitter.
module mcr_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  mcr_pkg::mcr_job_t push_job,
  output logic              full,
  output logic              q_valid,
  output mcr_pkg::mcr_job_t head,
  input  logic              pop
);
  import mcr_pkg::*;

  mcr_job_t          mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> q_valid)
    else $error("pop from empty queue");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count did not follow push");

endmodule

FILE: design/mcr_back.sv
// Pixel emitter: expands one job into eight symmetric pixels.
module mcr_back #(
  parameter int COORD_BITS = mcr_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  mcr_pkg::mcr_job_t            head,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS-1:0] point_x,
  output logic signed [COORD_BITS-1:0] point_y,
  output logic [23:0]                  pixel_color,
  output logic [2:0]                   octant,
  output logic                         last_of_step,
  output logic                         circle_done
);
  import mcr_pkg::*;

  mcr_job_t   job;
  logic       busy;
  logic [2:0] oct;

  logic              accept;
  logic              last;
  logic [CALC_W-1:0] mag_x;
  logic [CALC_W-1:0] mag_y;
  logic [CALC_W-1:0] off_x;
  logic [CALC_W-1:0] off_y;
  logic [CALC_W-1:0] sum_x;
  logic [CALC_W-1:0] sum_y;

  assign out_valid = busy;
  assign last      = (oct == OCT_LAST);
  assign accept    = busy && !out_stall;
  assign pop       = q_valid && (!busy || (accept && last));

  always_comb begin
    mag_x = oct[2] ? CALC_W'(job.y) : CALC_W'(job.x);
    mag_y = oct[2] ? CALC_W'(job.x) : CALC_W'(job.y);
    off_x = (oct[0] ^ oct[1]) ? -mag_x : mag_x;
    off_y = oct[1] ? -mag_y : mag_y;
    sum_x = {{(CALC_W-12){job.cx[11]}}, job.cx} + off_x;
    sum_y = {{(CALC_W-12){job.cy[11]}}, job.cy} + off_y;
  end

  assign point_x      = sum_x[COORD_BITS-1:0];
  assign point_y      = sum_y[COORD_BITS-1:0];
  assign pixel_color  = job.color;
  assign octant       = oct;
  assign last_of_step = last;
  assign circle_done  = job.done;

  always_ff @(posedge clk) begin
    if (pop) begin
      job <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      oct  <= '0;
    end else if (pop) begin
      busy <= 1'b1;
      oct  <= '0;
    end else if (accept) begin
      if (last) begin
        busy <= 1'b0;
      end
      oct <= oct + 3'd1;
    end
  end

  a_advance: assert property (@(posedge clk) disable iff (rst)
    (accept && !last) |=> (out_valid && octant == $past(octant) + 3'd1))
    else $error("octant did not advance after a pixel");
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (accept && last && !q_valid) |=> !out_valid)
    else $error("emitter stayed busy with no job");
  a_job_hold: assert property (@(posedge clk) disable iff (rst)
    (busy && !(accept && last)) |=> $stable(job))
    else $error("job changed in the middle of a step");

endmodule

FILE: design/midpoint_circle_rasterizer_core.sv
// Midpoint circle rasterizer top level. A start word (command 0) latches centre,
// radius and color and gives no pixels. A step word (command 1) is queued as a job,
// unless the circle is finished; the pixel emitter then gives its eight pixels one per
// cycle while out_stall is low. The job passes the queue, then the emitter's job
// register, before its first pixel appears. A two-job queue lets the front end keep
// taking words while pixels drain; in_stall rises when it is full.
module midpoint_circle_rasterizer_core #(
  parameter int COORD_BITS = mcr_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         command,
  input  logic signed [11:0]           center_x,
  input  logic signed [11:0]           center_y,
  input  logic [9:0]                   radius,
  input  logic [23:0]                  color_rgb,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS-1:0] point_x,
  output logic signed [COORD_BITS-1:0] point_y,
  output logic [23:0]                  pixel_color,
  output logic [2:0]                   octant,
  output logic                         last_of_step,
  output logic                         circle_done
);
  import mcr_pkg::*;

  logic     q_full;
  logic     push;
  mcr_job_t push_job;
  logic     q_valid;
  mcr_job_t head;
  logic     pop;

  mcr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .center_x  (center_x),
    .center_y  (center_y),
    .radius    (radius),
    .color_rgb (color_rgb),
    .q_full    (q_full),
    .push      (push),
    .push_job  (push_job)
  );

  mcr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .q_valid  (q_valid),
    .head     (head),
    .pop      (pop)
  );

  mcr_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .point_x      (point_x),
    .point_y      (point_y),
    .pixel_color  (pixel_color),
    .octant       (octant),
    .last_of_step (last_of_step),
    .circle_done  (circle_done)
  );

endmodule
